// ----- rtl/core/pcvr_pkg.sv -----
package pcvr_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_BITS  = 20;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

   // Fixed field widths of the channels
   localparam int INDEX_FIELD_BITS = 10;
   localparam int VALUE_FIELD_BITS = 20;
   localparam int COUNT_FIELD_BITS = 11;
   localparam int CMP_BITS = (VALUE_BITS > VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;

   localparam logic [COUNT_FIELD_BITS-1:0] COUNT_MAX = '1;

   // Trial divider: divisor, divisor squared, radix-16 remainder steps
   localparam int D_BITS      = (VALUE_BITS + 1) / 2 + 1;
   localparam int SQ_BITS     = VALUE_BITS + 2;
   localparam int RADIX_BITS  = 4;
   localparam int DIV_CYCLES  = (VALUE_BITS + RADIX_BITS - 1) / RADIX_BITS;
   localparam int DIV_BITS    = DIV_CYCLES * RADIX_BITS;
   localparam int STEP_BITS   = $clog2(DIV_CYCLES + 1);

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_ENTRY_COUNT = '0;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                        cmd;
      logic [INDEX_FIELD_BITS-1:0] entry_index;
      logic [VALUE_FIELD_BITS-1:0] entry_value;
      logic [VALUE_FIELD_BITS-1:0] low_value;
      logic [VALUE_FIELD_BITS-1:0] high_value;
   } req_type;

   typedef struct packed {
      logic [COUNT_FIELD_BITS-1:0] prime_count;
      logic                        found;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO_RD,
      ST_LO_CHK,
      ST_HI_RD,
      ST_HI_CHK,
      ST_CNT_RD,
      ST_CNT_LD,
      ST_TEST,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/core/prime_count_in_value_range.sv -----
// Sorted value table with a prime count over a value range. A load item
// (cmd 0) writes one table entry; loads are accepted whenever no query is in
// flight, also while a result waits. A query (cmd 1) locates the first index
// of low_value and the last index of high_value among the first entry_count
// entries, then counts the primes between them. All table reads go through
// one synchronous memory with a single read port, so each scan step takes a
// read state and a check state. Each entry in the found range is then read,
// loaded and tested: for each trial divisor d with d*d not above the value,
// the shared radix-16 remainder unit runs its DIV steps, and a zero remainder
// ends the entry early. The FINISH state hands the result to the output
// register once that is free. entry_count is written through the APB
// register at byte address 0 and must only change while no query is running.
module prime_count_in_value_range
   import pcvr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // control
   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COUNT_FIELD_BITS-1:0] entry_count_ff;

   // payload
   rsp_type                     rsp_data_ff, rsp_data_in;
   logic [CMP_BITS-1:0]         lo_ff, lo_in;
   logic [CMP_BITS-1:0]         hi_ff, hi_in;
   logic [CNT_BITS-1:0]         n_ff, n_in;
   logic [IDX_BITS-1:0]         i_ff, i_in;
   logic [IDX_BITS-1:0]         lo_idx_ff, lo_idx_in;
   logic [IDX_BITS-1:0]         hi_idx_ff, hi_idx_in;
   logic                        hi_found_ff, hi_found_in;
   logic                        found_ff, found_in;
   logic [COUNT_FIELD_BITS-1:0] count_ff, count_in;
   logic [VALUE_BITS-1:0]       nval_ff, nval_in;
   logic [D_BITS-1:0]           d_ff, d_in;
   logic [SQ_BITS-1:0]          dsq_ff, dsq_in;
   logic [D_BITS-1:0]           rem_ff, rem_in;
   logic [DIV_BITS-1:0]         shift_ff, shift_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;

   // table memory
   logic [VALUE_BITS-1:0]       table_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0]       rd_data_ff;
   logic                        mem_we;

   // decoded conditions
   logic                        req_accept;
   logic                        is_query;
   logic                        idx_ok;
   logic                        out_free;
   logic                        csr_write;
   logic [CNT_BITS-1:0]         n_lim;
   logic [CMP_BITS-1:0]         rd_cmp;
   logic                        rd_eq_lo, rd_eq_hi, rd_gt_hi, hi_hit;
   logic                        last_entry, hi_resolve;
   logic [IDX_BITS-1:0]         hi_idx_new;
   logic                        range_end;
   logic                        small_val, dsq_above;
   logic                        div_last;
   logic [D_BITS-1:0]           rem_step;
   logic                        entry_done, entry_prime;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign is_query   = (req_data.cmd == CMD_QUERY);
   assign idx_ok     = (32'(req_data.entry_index) < TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign mem_we     = req_accept && !is_query && idx_ok;

   assign n_lim = (32'(entry_count_ff) > TABLE_DEPTH) ? CNT_BITS'(TABLE_DEPTH)
                                                      : CNT_BITS'(entry_count_ff);

   assign rd_cmp     = CMP_BITS'(rd_data_ff);
   assign rd_eq_lo   = (rd_cmp == lo_ff);
   assign rd_eq_hi   = (rd_cmp == hi_ff);
   assign rd_gt_hi   = (rd_cmp > hi_ff);
   assign hi_hit     = hi_found_ff || rd_eq_hi;
   assign last_entry = ((CNT_BITS'(i_ff) + CNT_BITS'(1)) == n_ff);
   // range closes before the first larger entry after a match, else at the table end
   assign hi_resolve = (hi_hit && rd_gt_hi) || last_entry;
   assign hi_idx_new = (hi_hit && rd_gt_hi) ? (i_ff - IDX_BITS'(1))
                                            : IDX_BITS'(n_ff - CNT_BITS'(1));
   assign range_end  = (i_ff == hi_idx_ff);

   assign small_val  = (nval_ff < VALUE_BITS'(2));
   assign dsq_above  = (dsq_ff > SQ_BITS'(nval_ff));
   assign div_last   = (step_ff == STEP_BITS'(DIV_CYCLES - 1));

   // one entry of the range is settled in TEST (below 2 or out of divisors)
   // or at the end of a division with zero remainder
   always_comb begin : entry_status
      entry_done  = 1'b0;
      entry_prime = 1'b0;
      case (state_ff)
         ST_TEST: begin
            entry_done  = small_val || dsq_above;
            entry_prime = !small_val && dsq_above;
         end
         ST_DIV: begin
            entry_done  = div_last && (rem_step == '0);
         end
         default: begin
            entry_done  = 1'b0;
         end
      endcase
   end

   // radix-16 restoring remainder step
   always_comb begin : div_step
      logic [D_BITS-1:0] acc;
      logic [D_BITS:0]   trial;
      acc   = rem_ff;
      trial = '0;
      for (int k = 0; k < RADIX_BITS; k++) begin
         trial = {acc, shift_ff[DIV_BITS-1-k]};
         if (trial >= {1'b0, d_ff}) begin
            trial = trial - {1'b0, d_ff};
         end
         acc = trial[D_BITS-1:0];
      end
      rem_step = acc;
   end

   // next state
   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               state_in = (n_lim == '0) ? ST_FINISH : ST_LO_RD;
            end
         end
         ST_LO_RD: begin
            state_in = ST_LO_CHK;
         end
         ST_LO_CHK: begin
            if (rd_eq_lo) begin
               state_in = ST_HI_RD;
            end else if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LO_RD;
            end
         end
         ST_HI_RD: begin
            state_in = ST_HI_CHK;
         end
         ST_HI_CHK: begin
            if (hi_resolve) begin
               if (hi_hit && (lo_idx_ff <= hi_idx_new)) begin
                  state_in = ST_CNT_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_HI_RD;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_LD;
         end
         ST_CNT_LD: begin
            state_in = ST_TEST;
         end
         ST_TEST, ST_DIV: begin
            if (entry_done) begin
               state_in = range_end ? ST_FINISH : ST_CNT_RD;
            end else if (state_ff == ST_TEST) begin
               state_in = ST_DIV;
            end else if (div_last) begin
               state_in = ST_TEST;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin : datapath
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      lo_idx_in   = lo_idx_ff;
      hi_idx_in   = hi_idx_ff;
      hi_found_in = hi_found_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      nval_in     = nval_ff;
      d_in        = d_ff;
      dsq_in      = dsq_ff;
      rem_in      = rem_ff;
      shift_in    = shift_ff;
      step_in     = step_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (entry_prime && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_FIELD_BITS'(1);
      end
      if (entry_done && !range_end) begin
         i_in = i_ff + IDX_BITS'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               lo_in       = CMP_BITS'(req_data.low_value);
               hi_in       = CMP_BITS'(req_data.high_value);
               n_in        = n_lim;
               i_in        = '0;
               hi_found_in = 1'b0;
               found_in    = 1'b0;
               count_in    = '0;
            end
         end
         ST_LO_CHK: begin
            if (rd_eq_lo) begin
               lo_idx_in = i_ff;
               i_in      = '0;
            end else if (!last_entry) begin
               i_in = i_ff + IDX_BITS'(1);
            end
         end
         ST_HI_CHK: begin
            hi_found_in = hi_hit;
            if (hi_resolve) begin
               hi_idx_in = hi_idx_new;
               found_in  = hi_hit;
               i_in      = lo_idx_ff;
            end else begin
               i_in = i_ff + IDX_BITS'(1);
            end
         end
         ST_CNT_LD: begin
            nval_in = rd_data_ff;
            d_in    = D_BITS'(2);
            dsq_in  = SQ_BITS'(4);
         end
         ST_TEST: begin
            rem_in   = '0;
            shift_in = DIV_BITS'(nval_ff);
            step_in  = '0;
         end
         ST_DIV: begin
            rem_in   = rem_step;
            shift_in = shift_ff << RADIX_BITS;
            step_in  = step_ff + STEP_BITS'(1);
            if (div_last) begin
               // advance to the next divisor: (d+1)^2 = d^2 + 2d + 1
               d_in   = d_ff + D_BITS'(1);
               dsq_in = dsq_ff + SQ_BITS'({d_ff, 1'b1});
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found       = found_ff;
               rsp_data_in.prime_count = found_ff ? count_ff : '0;
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            entry_count_ff <= pwdata[COUNT_FIELD_BITS-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      lo_idx_ff   <= lo_idx_in;
      hi_idx_ff   <= hi_idx_in;
      hi_found_ff <= hi_found_in;
      found_ff    <= found_in;
      count_ff    <= count_in;
      nval_ff     <= nval_in;
      d_ff        <= d_in;
      dsq_ff      <= dsq_in;
      rem_ff      <= rem_in;
      shift_ff    <= shift_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table with one write and one read port: loads write while idle, the sequencer reads otherwise
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[IDX_BITS'(req_data.entry_index)] <= VALUE_BITS'(req_data.entry_value);
      end
      rd_data_ff <= table_mem[i_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_BITS-1:2] == REG_ENTRY_COUNT);
   assign prdata    = (paddr[CSR_ADDR_BITS-1:2] == REG_ENTRY_COUNT)
                      ? CSR_DATA_BITS'(entry_count_ff) : '0;

endmodule

// ----- rtl/core/pcvr_checker.sv -----
module pcvr_checker
   import pcvr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input req_type                  req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsp_type                  rsp_data,
   input logic                     psel,
   input logic                     penable,
   input logic                     pwrite,
   input logic [CSR_ADDR_BITS-1:0] paddr,
   input logic [CSR_DATA_BITS-1:0] pwdata,
   input logic [CSR_DATA_BITS-1:0] prdata,
   input logic                     pready
);

   // result held until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // an absent value reports a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.prime_count == '0)
      else $error("count reported without a match");

   // the count cannot exceed the table size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.prime_count) <= TABLE_DEPTH)
      else $error("count above table depth");

   // no result leaves straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a query blocks further requests until it is done
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == CMD_QUERY |=> !req_ready)
      else $error("request taken while a query runs");

endmodule

bind prime_count_in_value_range pcvr_checker u_pcvr_checker (.*);
